[src/pwpd_pkg.sv]
// Shared types, codes and reset constants of the pulse width packet decoder.
package pwpd_pkg;

  localparam int unsigned CodeBitsDef   = 32;
  localparam int unsigned TickBitsDef   = 15;
  localparam int unsigned MaxSymbolsDef = 64;

  localparam int unsigned ExpBitsW   = 6;
  localparam int unsigned CfgIndexW  = 3;
  localparam int unsigned CodeOutW   = 32;
  localparam int unsigned QueueDepth = 2;

  localparam int unsigned RstShortLow  = 22;
  localparam int unsigned RstShortHigh = 28;
  localparam int unsigned RstLongLow   = 22;
  localparam int unsigned RstLongHigh  = 28;
  localparam int unsigned RstExpBits   = 25;

  typedef enum logic [CfgIndexW-1:0] {
    CFG_SHORT_LOW  = 3'd0,
    CFG_SHORT_HIGH = 3'd1,
    CFG_LONG_LOW   = 3'd2,
    CFG_LONG_HIGH  = 3'd3,
    CFG_EXP_BITS   = 3'd4
  } pwpd_cfg_idx_e;

  typedef enum logic [1:0] {
    SYM_ONE  = 2'd0,
    SYM_ZERO = 2'd1,
    SYM_BAD  = 2'd2
  } pwpd_sym_kind_e;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_BAD_COUNT = 2'd1,
    STATUS_BAD_PULSE = 2'd2
  } pwpd_status_e;

  typedef struct packed {
    pwpd_sym_kind_e kind;
    logic           last;
  } pwpd_sym_t;

endpackage

[src/pwpd_front.sv]
// Front end: holds the tick windows and classifies each incoming symbol.
module pwpd_front #(
  parameter int unsigned TICK_BITS = pwpd_pkg::TickBitsDef,
  parameter int unsigned TDATA_W   = ((TICK_BITS + 7) / 8) * 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [pwpd_pkg::CfgIndexW-1:0] cfg_index_i,
  input  logic [TICK_BITS-1:0]           cfg_wdata_i,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [TDATA_W-1:0]             s_axis_tdata,
  input  logic                           s_axis_tlast,
  output logic                           sym_valid_o,
  input  logic                           sym_ready_i,
  output pwpd_pkg::pwpd_sym_t            sym_o
);
  import pwpd_pkg::*;

  logic [TICK_BITS-1:0] short_low_q, short_high_q, long_low_q, long_high_q;
  logic [TICK_BITS-1:0] ticks;
  logic                 in_short, in_long;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      short_low_q  <= TICK_BITS'(RstShortLow);
      short_high_q <= TICK_BITS'(RstShortHigh);
      long_low_q   <= TICK_BITS'(RstLongLow);
      long_high_q  <= TICK_BITS'(RstLongHigh);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_SHORT_LOW:  short_low_q  <= cfg_wdata_i;
        CFG_SHORT_HIGH: short_high_q <= cfg_wdata_i;
        CFG_LONG_LOW:   long_low_q   <= cfg_wdata_i;
        CFG_LONG_HIGH:  long_high_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign ticks    = s_axis_tdata[TICK_BITS-1:0];
  assign in_short = (ticks > short_low_q) && (ticks < short_high_q);
  assign in_long  = (ticks > long_low_q) && (ticks < long_high_q);

  // The short window is tested first, so it wins where the windows overlap.
  always_comb begin
    if (in_short) begin
      sym_o.kind = SYM_ONE;
    end else if (in_long) begin
      sym_o.kind = SYM_ZERO;
    end else begin
      sym_o.kind = SYM_BAD;
    end
    sym_o.last = s_axis_tlast;
  end

  assign sym_valid_o   = s_axis_tvalid;
  assign s_axis_tready = sym_ready_i;

endmodule

[src/pwpd_queue.sv]
// Two-entry queue of classified symbols between the front and back ends.
module pwpd_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_valid_i,
  output logic                push_ready_o,
  input  pwpd_pkg::pwpd_sym_t push_data_i,
  output logic                pop_valid_o,
  input  logic                pop_ready_i,
  output pwpd_pkg::pwpd_sym_t pop_data_o
);
  import pwpd_pkg::*;

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  pwpd_sym_t       entry_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            push, pop;

  assign push_ready_o = (count_q != CntW'(QueueDepth));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_ready_i && pop_valid_o;
  assign pop_data_o   = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(QueueDepth))
    else $error("queue count exceeds its depth");

  a_count_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> (count_q == $past(count_q) + 1'b1))
    else $error("queue count missed a request");
`endif

endmodule

[src/pwpd_back.sv]
// Back end: shifts the code, counts symbols and registers the packet result.
module pwpd_back #(
  parameter int unsigned CODE_BITS   = pwpd_pkg::CodeBitsDef,
  parameter int unsigned MAX_SYMBOLS = pwpd_pkg::MaxSymbolsDef,
  parameter int unsigned CFG_W       = pwpd_pkg::TickBitsDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [pwpd_pkg::CfgIndexW-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]               cfg_wdata_i,
  input  logic                           sym_valid_i,
  output logic                           sym_ready_o,
  input  pwpd_pkg::pwpd_sym_t            sym_i,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [pwpd_pkg::CodeOutW-1:0]  m_axis_tdata,
  output logic [1:0]                     m_axis_tuser
);
  import pwpd_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_SYMBOLS + 1);

  logic [ExpBitsW-1:0]              exp_bits_q;
  logic [CODE_BITS-1:0]             shift_q, shift_d;
  logic [CntW-1:0]                  count_q, count_d;
  logic                             bad_q, bad_d;
  logic                             out_valid_q;
  logic [CodeOutW-1:0]              code_q, code_d;
  pwpd_status_e                     status_q, status_d;
  logic [CODE_BITS+CodeOutW-1:0]    shift_ext;
  logic                             pop, emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_bits_q <= ExpBitsW'(RstExpBits);
    end else if (cfg_we_i && (cfg_index_i == CFG_EXP_BITS)) begin
      exp_bits_q <= cfg_wdata_i[ExpBitsW-1:0];
    end
  end

  // A symbol that closes a packet waits until the output register is free.
  assign sym_ready_o = !sym_i.last || !out_valid_q || m_axis_tready;
  assign pop         = sym_valid_i && sym_ready_o;
  assign emit        = pop && sym_i.last;

  always_comb begin
    shift_d = shift_q;
    bad_d   = bad_q;
    count_d = count_q;
    unique case (sym_i.kind)
      SYM_ONE:  shift_d = {shift_q[CODE_BITS-2:0], 1'b1};
      SYM_ZERO: shift_d = {shift_q[CODE_BITS-2:0], 1'b0};
      default:  bad_d   = 1'b1;
    endcase
    if (count_q < CntW'(MAX_SYMBOLS)) begin
      count_d = count_q + 1'b1;
    end
  end

  assign shift_ext = {{CodeOutW{1'b0}}, shift_d};

  always_comb begin
    if (count_d != CntW'(exp_bits_q)) begin
      status_d = STATUS_BAD_COUNT;
      code_d   = '0;
    end else if (bad_d) begin
      status_d = STATUS_BAD_PULSE;
      code_d   = '0;
    end else begin
      status_d = STATUS_OK;
      code_d   = shift_ext[CodeOutW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q     <= '0;
      count_q     <= '0;
      bad_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (emit) begin
        shift_q <= '0;
        count_q <= '0;
        bad_q   <= 1'b0;
      end else if (pop) begin
        shift_q <= shift_d;
        count_q <= count_d;
        bad_q   <= bad_d;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      code_q   <= code_d;
      status_q <= status_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = code_q;
  assign m_axis_tuser  = status_q;

`ifndef NO_ASSERTIONS
  a_code_zero_on_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (status_q != STATUS_OK)) |-> (code_q == '0))
    else $error("nonzero code with an error status");

  a_count_saturates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MAX_SYMBOLS))
    else $error("symbol count passed its ceiling");

  a_clear_after_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> ((count_q == '0) && !bad_q && out_valid_q))
    else $error("packet state not cleared after a result");
`endif

endmodule

[src/pulse_width_packet_decoder_top.sv]
// Top level of the pulse width packet decoder.
// Each request on the input stream is one pulse symbol: the high-phase duration in ticks in
// tdata and the final-symbol mark in tlast. The block takes one symbol per clock cycle while
// the queue has room. The front end classifies a symbol against the tick windows in the cycle
// it is accepted and places it in a two-entry queue. The back end takes it from the queue once
// ready, and on taking a final symbol it loads the packet code and status into the output
// register, so a result passes through the queue entry and then the output register. A final
// symbol waits in the queue while the previous result is still unaccepted, and the input
// stalls once the queue is full. Configuration writes are taken at any edge with the write
// enable high and must only be made while the block is idle.
module pulse_width_packet_decoder_top #(
  parameter int unsigned CODE_BITS   = pwpd_pkg::CodeBitsDef,
  parameter int unsigned TICK_BITS   = pwpd_pkg::TickBitsDef,
  parameter int unsigned MAX_SYMBOLS = pwpd_pkg::MaxSymbolsDef,
  parameter int unsigned TDATA_W     = ((TICK_BITS + 7) / 8) * 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [pwpd_pkg::CfgIndexW-1:0] cfg_index_i,
  input  logic [TICK_BITS-1:0]           cfg_wdata_i,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [TDATA_W-1:0]             s_axis_tdata,   // high_ticks, zero padding above
  input  logic                           s_axis_tlast,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [pwpd_pkg::CodeOutW-1:0]  m_axis_tdata,   // packet_code
  output logic [1:0]                     m_axis_tuser    // status
);
  import pwpd_pkg::*;

  logic      front_valid, front_ready;
  pwpd_sym_t front_sym;
  logic      back_valid, back_ready;
  pwpd_sym_t back_sym;

  pwpd_front #(
    .TICK_BITS (TICK_BITS),
    .TDATA_W   (TDATA_W)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .sym_valid_o   (front_valid),
    .sym_ready_i   (front_ready),
    .sym_o         (front_sym)
  );

  pwpd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .push_data_i  (front_sym),
    .pop_valid_o  (back_valid),
    .pop_ready_i  (back_ready),
    .pop_data_o   (back_sym)
  );

  pwpd_back #(
    .CODE_BITS   (CODE_BITS),
    .MAX_SYMBOLS (MAX_SYMBOLS),
    .CFG_W       (TICK_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .sym_valid_i   (back_valid),
    .sym_ready_o   (back_ready),
    .sym_i         (back_sym),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule
